>>> design/ccsr_pkg.sv
// Shared types, constants and geometry for the color cell symbol reader.
`timescale 1ns / 1ps

package ccsr_pkg;

  // Code geometry.
  localparam int unsigned GRID_WIDTH   = 64;
  localparam int unsigned GRID_HEIGHT  = 64;
  localparam int unsigned BORDER_CELLS = 2;
  localparam int unsigned CELL_PIXELS  = 8;

  // A finder corner covers its 7-cell pattern plus a one-cell quiet ring.
  localparam int unsigned FinderPattern = 7;
  localparam int unsigned FinderQuiet   = 1;
  localparam int unsigned FinderSpan    = BORDER_CELLS + FinderPattern + FinderQuiet;

  // Field widths.
  localparam int unsigned PixW   = 9;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned SymW   = 2;
  localparam int unsigned CellW  = 6;
  localparam int unsigned CountW = 13;
  localparam logic [CountW-1:0] CountMax = '1;

  // Cell index from pixel position: multiply by a scaled reciprocal.
  localparam int unsigned DivShift = 16;
  localparam int unsigned DivMul   = ((1 << DivShift) + CELL_PIXELS - 1) / CELL_PIXELS;
  localparam int unsigned DivMulW  = $clog2(DivMul + 1);
  localparam int unsigned QuotW    = $clog2((1 << PixW) / CELL_PIXELS);
  localparam int unsigned CmpW     = 10;

  // Configuration registers: low and high bound per color class.
  localparam int unsigned NumClasses = 4;
  localparam int unsigned NumRegs    = 2 * NumClasses;
  localparam int unsigned BoundW     = 3 * ChanW;
  localparam int unsigned RegIdxW    = $clog2(NumRegs);
  localparam int unsigned AddrW      = RegIdxW + 2;
  localparam int unsigned DataW      = 32;

  typedef logic [NumRegs-1:0][BoundW-1:0] bounds_t;

  // Register 0 is the black low bound; register 7 is the white high bound.
  localparam bounds_t BoundsReset = {
    24'hFFFFFF, 24'hBEBEBE,
    24'hFFB4B4, 24'h962800,
    24'h87D3FF, 24'h003C96,
    24'h959595, 24'h000000
  };

  // Decoded symbols in test order.
  typedef enum logic [SymW-1:0] {
    SymBlack  = 2'd0,
    SymBlue   = 2'd1,
    SymOrange = 2'd2,
    SymWhite  = 2'd3
  } sym_e;

  typedef struct packed {
    logic              frame_start;
    logic [PixW-1:0]   pix_row;
    logic [PixW-1:0]   pix_col;
    logic [ChanW-1:0]  chan0;
    logic [ChanW-1:0]  chan1;
    logic [ChanW-1:0]  chan2;
    logic [SymW-1:0]   expected_sym;
  } in_item_t;

  typedef struct packed {
    logic [CellW-1:0]  cell_row;
    logic [CellW-1:0]  cell_col;
    logic [SymW-1:0]   sym;
    logic              no_match;
    logic              mismatch;
    logic [CountW-1:0] error_count;
  } out_item_t;

  // Classification of one pixel, handed from the classifier to the top.
  typedef struct packed {
    logic              sample;
    logic [CellW-1:0]  cell_row;
    logic [CellW-1:0]  cell_col;
    logic [SymW-1:0]   sym;
    logic              no_match;
    logic              mismatch;
  } class_res_t;

endpackage

>>> design/ccsr_regs.sv
// APB register file holding the color class box bounds.
`timescale 1ns / 1ps

module ccsr_regs import ccsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output bounds_t          bounds_o
);

  bounds_t              bounds_q;
  logic [RegIdxW-1:0]   reg_idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en = psel & penable & pwrite & pready;

  // Register write in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= BoundsReset;
    end else if (wr_en) begin
      bounds_q[reg_idx] <= pwdata[BoundW-1:0];
    end
  end

  // Read data, zero extended to the bus width.
  assign prdata = DataW'(bounds_q[reg_idx]);
  assign bounds_o = bounds_q;

endmodule

>>> design/ccsr_classify.sv
// Cell position decode and color box classification of one pixel.
`timescale 1ns / 1ps

module ccsr_classify import ccsr_pkg::*; (
  input  in_item_t   item_i,
  input  bounds_t    bounds_i,
  output class_res_t res_o
);

  logic [PixW+DivMulW-1:0] row_prod;
  logic [PixW+DivMulW-1:0] col_prod;
  logic [QuotW-1:0]        row_q;
  logic [QuotW-1:0]        col_q;
  logic [PixW-1:0]         row_rem;
  logic [PixW-1:0]         col_rem;
  logic [CmpW-1:0]         r;
  logic [CmpW-1:0]         c;
  logic                    centre;
  logic                    in_margin;
  logic                    near_top;
  logic                    near_bottom;
  logic                    near_left;
  logic                    near_right;
  logic                    finder;
  logic [NumClasses-1:0]   hit;
  logic [SymW-1:0]         sym;
  logic                    found;

  // Cell index and offset within the cell.
  assign row_prod = (PixW + DivMulW)'(item_i.pix_row) * (PixW + DivMulW)'(DivMul);
  assign col_prod = (PixW + DivMulW)'(item_i.pix_col) * (PixW + DivMulW)'(DivMul);
  assign row_q = row_prod[DivShift +: QuotW];
  assign col_q = col_prod[DivShift +: QuotW];
  assign row_rem = item_i.pix_row - PixW'(PixW'(row_q) * PixW'(CELL_PIXELS));
  assign col_rem = item_i.pix_col - PixW'(PixW'(col_q) * PixW'(CELL_PIXELS));
  assign centre = (row_rem == PixW'(CELL_PIXELS / 2)) && (col_rem == PixW'(CELL_PIXELS / 2));

  // Margin and finder corner exclusion.
  assign r = CmpW'(row_q);
  assign c = CmpW'(col_q);
  assign in_margin = (r >= CmpW'(BORDER_CELLS)) && (r < CmpW'(GRID_HEIGHT - BORDER_CELLS)) &&
                     (c >= CmpW'(BORDER_CELLS)) && (c < CmpW'(GRID_WIDTH - BORDER_CELLS));
  assign near_top    = r <= CmpW'(FinderSpan);
  assign near_bottom = r >= CmpW'(GRID_HEIGHT - FinderSpan - 1);
  assign near_left   = c <= CmpW'(FinderSpan);
  assign near_right  = c >= CmpW'(GRID_WIDTH - FinderSpan - 1);
  assign finder = (near_top && (near_left || near_right)) || (near_bottom && near_left);

  // Inclusive per-channel box test for every class.
  always_comb begin
    for (int k = 0; k < NumClasses; k++) begin
      hit[k] =
        (item_i.chan0 >= bounds_i[2*k][0 +: ChanW]) &&
        (item_i.chan0 <= bounds_i[2*k+1][0 +: ChanW]) &&
        (item_i.chan1 >= bounds_i[2*k][ChanW +: ChanW]) &&
        (item_i.chan1 <= bounds_i[2*k+1][ChanW +: ChanW]) &&
        (item_i.chan2 >= bounds_i[2*k][2*ChanW +: ChanW]) &&
        (item_i.chan2 <= bounds_i[2*k+1][2*ChanW +: ChanW]);
    end
  end

  // The first matching class in test order gives the symbol.
  always_comb begin
    sym = SymBlack;
    found = 1'b0;
    for (int k = 0; k < NumClasses; k++) begin
      if (hit[k] && !found) begin
        sym = SymW'(k);
        found = 1'b1;
      end
    end
  end

  assign res_o.sample   = centre && in_margin && !finder;
  assign res_o.cell_row = row_q[CellW-1:0];
  assign res_o.cell_col = col_q[CellW-1:0];
  assign res_o.sym      = sym;
  assign res_o.no_match = !found;
  assign res_o.mismatch = !found || (sym != item_i.expected_sym);

endmodule

>>> design/color_cell_symbol_reader.sv
// Top level of the color cell symbol reader: pipeline, error counter, ports.
`timescale 1ns / 1ps

// Takes one pixel per clock while the output side does not stall, and emits
// a transaction only for the center pixel of a data cell that lies inside the
// margin and outside the three finder corners. Each pixel is held in the input
// register and its result is then registered in the output register.
// in_ready_o follows out_ready_i within the cycle when both stages hold work
// and the held pixel yields a result; pixels that yield no result never wait
// on the output side. The error count clears on frame_start and saturates at
// 8191. The box bounds are to be written through the APB port only while no
// transaction is in flight; the block itself does not enforce this.
module color_cell_symbol_reader import ccsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  bounds_t           bounds;
  in_item_t          s1_data_q;
  logic              s1_valid_q;
  logic              s1_valid_d;
  class_res_t        res;
  logic              out_free;
  logic              adv1;
  logic              out_valid_q;
  logic              out_valid_d;
  out_item_t         out_data_q;
  logic [CountW-1:0] cnt_q;
  logic [CountW-1:0] cnt_d;
  logic [CountW-1:0] cnt_base;

  ccsr_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .bounds_o (bounds)
  );

  ccsr_classify u_classify (
    .item_i   (s1_data_q),
    .bounds_i (bounds),
    .res_o    (res)
  );

  // Stage handshakes: a pixel without a result leaves the input stage freely.
  assign out_free   = !out_valid_q || out_ready_i;
  assign adv1       = s1_valid_q && (!res.sample || out_free);
  assign in_ready_o = !s1_valid_q || adv1;

  // Input stage.
  assign s1_valid_d = (in_valid_i && in_ready_o) || (s1_valid_q && !adv1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // Per-frame error counter, updated as each pixel leaves the input stage.
  always_comb begin
    cnt_base = s1_data_q.frame_start ? '0 : cnt_q;
    cnt_d = cnt_base;
    if (res.sample && res.mismatch && (cnt_base != CountMax)) begin
      cnt_d = cnt_base + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (adv1) begin
      cnt_q <= cnt_d;
    end
  end

  // Output register.
  assign out_valid_d = (adv1 && res.sample) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && res.sample) begin
      out_data_q.cell_row    <= res.cell_row;
      out_data_q.cell_col    <= res.cell_col;
      out_data_q.sym         <= res.sym;
      out_data_q.no_match    <= res.no_match;
      out_data_q.mismatch    <= res.mismatch;
      out_data_q.error_count <= cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A miss always counts as a mismatch and reports symbol black.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_match |-> out_data_o.mismatch &&
    (out_data_o.sym == SymBlack))
    else $error("no-match result without mismatch or with nonzero symbol");

  // A delivered mismatch has been counted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mismatch |-> out_data_o.error_count != '0)
    else $error("mismatch delivered with zero error count");

  // An unsaturated mismatch within a frame bumps the counter by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv1 && !s1_data_q.frame_start && res.sample && res.mismatch &&
    (cnt_q != CountMax) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("error counter failed to advance");

  // A pixel with a result leaves the input stage only when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv1 && res.sample |-> out_free)
    else $error("result would overwrite a pending transaction");

endmodule

>>> tb/tb_color_cell_symbol_reader.sv
// Self-checking testbench for the color cell symbol reader.
`timescale 1ns / 1ps

module tb_color_cell_symbol_reader;
  import ccsr_pkg::*;

  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned ResetCycles  = 6;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned PhaseItems   = 260;
  localparam int unsigned FailItems    = 280;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_item_t         in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_item_t        out_data_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Tracks box bounds and the frame error tally, and holds the cell results still due.
  class cell_result_board;
    logic [BoundW-1:0] bounds [NumRegs];
    logic [CountW-1:0] err_tally;
    out_item_t         pending_cells [$];
    int unsigned       fault_count;
    int unsigned       pixels_seen;
    int unsigned       cells_seen;
    int unsigned       flagged_cells;

    function new();
      foreach (bounds[i]) bounds[i] = BoundsReset[i];
      err_tally = '0;
    endfunction

    // A pixel lies in a box when every channel is within its inclusive bounds.
    function bit in_class(int unsigned k, in_item_t px);
      logic [BoundW-1:0] lo, hi;
      lo = bounds[2*k];
      hi = bounds[2*k+1];
      return px.chan0 >= lo[7:0]   && px.chan0 <= hi[7:0] &&
             px.chan1 >= lo[15:8]  && px.chan1 <= hi[15:8] &&
             px.chan2 >= lo[23:16] && px.chan2 <= hi[23:16];
    endfunction

    // Three corners carry finder patterns; the bottom-right one does not.
    function bit in_finder(int unsigned r, int unsigned c);
      bit near_top, near_bottom, near_left, near_right;
      near_top    = r <= FinderSpan;
      near_bottom = r >= GRID_HEIGHT - FinderSpan - 1;
      near_left   = c <= FinderSpan;
      near_right  = c >= GRID_WIDTH - FinderSpan - 1;
      return (near_top && (near_left || near_right)) || (near_bottom && near_left);
    endfunction

    // Works out the result, if any, that an accepted pixel transaction causes.
    function void judge_pixel(in_item_t px);
      int unsigned r, c;
      out_item_t   due;
      sym_e        hue;
      pixels_seen++;
      if (px.frame_start) err_tally = '0;
      if (px.pix_row % CELL_PIXELS != CELL_PIXELS / 2) return;
      if (px.pix_col % CELL_PIXELS != CELL_PIXELS / 2) return;
      r = px.pix_row / CELL_PIXELS;
      c = px.pix_col / CELL_PIXELS;
      if (r < BORDER_CELLS || r >= GRID_HEIGHT - BORDER_CELLS) return;
      if (c < BORDER_CELLS || c >= GRID_WIDTH - BORDER_CELLS) return;
      if (in_finder(r, c)) return;
      due = '0;
      due.cell_row = CellW'(r);
      due.cell_col = CellW'(c);
      due.no_match = 1'b1;
      hue = SymBlack;
      // The first box in test order wins.
      for (int k = 0; k < NumClasses; k++) begin
        if (in_class(k, px)) begin
          hue = sym_e'(k);
          due.no_match = 1'b0;
          break;
        end
      end
      due.sym = hue;
      due.mismatch = due.no_match || (hue != px.expected_sym);
      if (due.mismatch) begin
        flagged_cells++;
        if (err_tally != CountMax) err_tally++;
      end
      due.error_count = err_tally;
      pending_cells = {pending_cells, due};
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fault_count++;
      end
    endfunction

    // Compares an accepted result transaction with the oldest one due.
    function void compare_cell(out_item_t got);
      out_item_t want;
      if (pending_cells.size() == 0) begin
        $error("unexpected cell result at row %0d col %0d", got.cell_row, got.cell_col);
        fault_count++;
        return;
      end
      want = pending_cells.pop_front();
      cells_seen++;
      check_field("cell_row", want.cell_row, got.cell_row);
      check_field("cell_col", want.cell_col, got.cell_col);
      check_field("sym", want.sym, got.sym);
      check_field("no_match", want.no_match, got.no_match);
      check_field("mismatch", want.mismatch, got.mismatch);
      check_field("error_count", want.error_count, got.error_count);
    endfunction
  endclass

  cell_result_board board;
  bit               steady;
  bit               hold_req;
  int unsigned      hold_left;
  int unsigned      stall_cycles;
  int unsigned      settings_used;

  color_cell_symbol_reader uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= 10);
    end
  end

  // Monitor of both channels, and a watchdog on cycles without progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.judge_pixel(in_data_i);
      if (out_valid_o && out_ready_i) board.compare_cell(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("color_cell_symbol_reader verification failed");
        $finish;
      end
    end
  end

  // Offers one pixel transaction, sometimes after a short gap, and waits for it.
  task automatic send_pixel(input in_item_t px);
    if (!steady && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_at(input int unsigned row, input int unsigned col,
                         input logic [BoundW-1:0] rgb, input sym_e want_sym,
                         input logic fs);
    in_item_t px;
    px.frame_start  = fs;
    px.pix_row      = PixW'(row);
    px.pix_col      = PixW'(col);
    {px.chan2, px.chan1, px.chan0} = rgb;
    px.expected_sym = want_sym;
    send_pixel(px);
  endtask

  // Sends the center pixel of grid cell (r, c).
  task automatic send_cell(input int unsigned r, input int unsigned c,
                           input logic [BoundW-1:0] rgb, input sym_e want_sym,
                           input logic fs = 1'b0);
    send_at(r * CELL_PIXELS + CELL_PIXELS / 2, c * CELL_PIXELS + CELL_PIXELS / 2,
            rgb, want_sym, fs);
  endtask

  // Waits until every result has arrived and the pipeline has emptied.
  task automatic settle();
    @(posedge clk_i);
    while (board.pending_cells.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_bound(input int unsigned idx, input logic [BoundW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * idx);
    pwdata  <= DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.bounds[idx] = value;
  endtask

  task automatic load_bounds(input bounds_t setting);
    for (int i = 0; i < NumRegs; i++) write_bound(i, setting[i]);
    settings_used++;
  endtask

  // Random box bounds; about one channel in ten is left empty.
  function automatic bounds_t random_bounds();
    bounds_t     b;
    logic [7:0]  a, z;
    for (int k = 0; k < NumClasses; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        a = 8'($urandom_range(255));
        z = 8'($urandom_range(255));
        if (a > z) {a, z} = {z, a};
        if ($urandom_range(9) == 0) {a, z} = {z, a};
        b[2*k][8*ch +: 8]   = a;
        b[2*k+1][8*ch +: 8] = z;
      end
    end
    return b;
  endfunction

  // Picks a color inside, on the edge of, or away from a random box.
  function automatic logic [BoundW-1:0] pick_colour(output sym_e hint);
    int unsigned       mode, k;
    logic [BoundW-1:0] lo, hi, rgb;
    logic [7:0]        l, h;
    mode = $urandom_range(9);
    k    = $urandom_range(NumClasses - 1);
    hint = sym_e'(k);
    lo   = board.bounds[2*k];
    hi   = board.bounds[2*k+1];
    for (int ch = 0; ch < 3; ch++) begin
      l = lo[8*ch +: 8];
      h = hi[8*ch +: 8];
      case (mode)
        0, 1, 2, 3, 4, 5: begin
          rgb[8*ch +: 8] = (l <= h) ? 8'($urandom_range(h, l)) : 8'($urandom_range(255));
        end
        6, 7: begin
          case ($urandom_range(3))
            0:       rgb[8*ch +: 8] = l;
            1:       rgb[8*ch +: 8] = h;
            2:       rgb[8*ch +: 8] = 8'(l - 8'd1);
            default: rgb[8*ch +: 8] = 8'(h + 8'd1);
          endcase
        end
        8:       rgb[8*ch +: 8] = 8'($urandom_range(255));
        default: rgb[8*ch +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
    end
    return rgb;
  endfunction

  // Mostly center pixels of data cells; the rest is anywhere in the image.
  function automatic in_item_t random_pixel();
    in_item_t    px;
    int unsigned r, c;
    sym_e        hint;
    {px.chan2, px.chan1, px.chan0} = pick_colour(hint);
    if ($urandom_range(99) < 85) begin
      do begin
        r = $urandom_range(GRID_HEIGHT - BORDER_CELLS - 1, BORDER_CELLS);
        c = $urandom_range(GRID_WIDTH - BORDER_CELLS - 1, BORDER_CELLS);
      end while (board.in_finder(r, c));
      px.pix_row = PixW'(r * CELL_PIXELS + CELL_PIXELS / 2);
      px.pix_col = PixW'(c * CELL_PIXELS + CELL_PIXELS / 2);
    end else begin
      px.pix_row = PixW'($urandom_range((1 << PixW) - 1));
      px.pix_col = PixW'($urandom_range((1 << PixW) - 1));
    end
    px.expected_sym = ($urandom_range(3) != 0) ? hint : sym_e'($urandom_range(3));
    px.frame_start  = ($urandom_range(39) == 0);
    return px;
  endfunction

  initial begin
    bounds_t     setting;
    int unsigned r, c;
    board       = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    steady      = 1'b0;
    hold_req    = 1'b0;
    hold_left   = 0;
    stall_cycles = 0;
    settings_used = 1;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cells under the reset bounds: each color, a miss, box edges.
    send_cell(2, 11, 24'h000000, SymBlack, 1'b1);
    send_cell(11, 2, 24'h2080C0, SymBlue);
    send_cell(30, 30, 24'hE06020, SymBlue);
    send_cell(61, 61, 24'hFFFFFF, SymWhite);
    send_cell(53, 53, 24'h1010A0, SymBlack);
    send_cell(2, 52, 24'h959595, SymWhite);
    send_cell(52, 2, 24'h969696, SymOrange);
    // Off-center pixel, margin cells, finder corners and image extremes.
    send_at(5, 20, 24'h000000, SymBlack, 1'b0);
    send_cell(0, 30, 24'h000000, SymBlack);
    send_cell(63, 30, 24'h000000, SymBlack);
    send_cell(30, 1, 24'h000000, SymBlack);
    send_cell(30, 62, 24'h000000, SymBlack);
    send_cell(10, 10, 24'h000000, SymWhite);
    send_cell(10, 53, 24'h000000, SymWhite);
    send_cell(53, 10, 24'h000000, SymWhite);
    send_at(511, 511, 24'hFFFFFF, SymWhite, 1'b1);
    send_at(0, 0, 24'h000000, SymBlack, 1'b0);
    // A frame start on an excluded pixel still clears the tally.
    send_cell(10, 10, 24'hFFFFFF, SymBlack, 1'b1);
    send_cell(20, 20, 24'h1010A0, SymBlack);
    in_valid_i <= 1'b0;
    settle();

    // Empty black box and overlapping full boxes: blue wins everything.
    setting = {24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000,
               24'hFFFFFF, 24'h000000, 24'hFFFF7F, 24'h000080};
    load_bounds(setting);
    send_cell(40, 40, 24'h101010, SymBlue);
    send_cell(40, 41, 24'h909090, SymOrange);
    send_cell(41, 40, 24'hFFFFFF, SymWhite);
    in_valid_i <= 1'b0;
    settle();

    // Random phases over several bound settings, the extremes among them.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       setting = BoundsReset;
        2:       setting = '0;
        3:       setting = '1;
        default: setting = random_bounds();
      endcase
      load_bounds(setting);
      steady = (ph == 1);
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 0 && n == PhaseItems / 2) hold_req = 1'b1;
        if (ph == 4 && n == PhaseItems / 2) begin
          in_valid_i <= 1'b0;
          settle();
        end
        send_pixel(random_pixel());
      end
      in_valid_i <= 1'b0;
      settle();
    end

    // A long frame of failing cells sent back to back.
    load_bounds(BoundsReset);
    steady = 1'b1;
    for (int n = 0; n < FailItems; n++) begin
      do begin
        r = $urandom_range(GRID_HEIGHT - BORDER_CELLS - 1, BORDER_CELLS);
        c = $urandom_range(GRID_WIDTH - BORDER_CELLS - 1, BORDER_CELLS);
      end while (board.in_finder(r, c));
      send_cell(r, c, 24'hFFFFFF, SymBlack, n == 0);
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;
    settle();
    repeat (4 * SettleCycles) @(posedge clk_i);

    $display("Run covered %0d pixels and %0d checked cell results under %0d bound settings,",
             board.pixels_seen, board.cells_seen, settings_used);
    $display("with %0d flagged cells, finder and margin exclusion, and a long failing frame.",
             board.flagged_cells);
    if (board.fault_count == 0) begin
      $display("color_cell_symbol_reader verification clean");
    end else begin
      $display("color_cell_symbol_reader verification failed");
    end
    $finish;
  end

endmodule
